FILE: rtl/ps2mt_pkg.sv
`timescale 1ns / 1ps

package ps2mt_pkg;

    localparam int unsigned CFG_W   = 10;
    localparam int unsigned POS_W   = 10;
    localparam int unsigned COLOR_W = 3;
    localparam int unsigned WIN_W   = 16;
    localparam int unsigned DELTA_W = 9;
    localparam int unsigned MOVE_W  = 12;  // moved cursor, signed
    localparam int unsigned CMP_W   = 18;  // window bounds, signed
    localparam int unsigned OUT_W   = 56;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = 1;
    localparam int unsigned QCNT_W      = 2;

    localparam logic [1:0] REG_SCREEN_W = 2'd0;
    localparam logic [1:0] REG_SCREEN_H = 2'd1;
    localparam logic [1:0] REG_WINDOW_W = 2'd2;
    localparam logic [1:0] REG_WINDOW_H = 2'd3;

    localparam logic [CFG_W-1:0] SCREEN_W_RST = 10'd320;
    localparam logic [CFG_W-1:0] SCREEN_H_RST = 10'd200;
    localparam logic [CFG_W-1:0] WINDOW_W_RST = 10'd100;
    localparam logic [CFG_W-1:0] WINDOW_H_RST = 10'd50;

    localparam logic [POS_W-1:0] POS_X_RST = 10'd160;
    localparam logic [POS_W-1:0] POS_Y_RST = 10'd100;
    localparam logic [WIN_W-1:0] WIN_L_RST = 16'd50;
    localparam logic [WIN_W-1:0] WIN_T_RST = 16'd50;

    localparam logic [COLOR_W-1:0] COLOR_INIT   = 3'd1;
    localparam logic [COLOR_W-1:0] COLOR_LEFT   = 3'd4;
    localparam logic [COLOR_W-1:0] COLOR_RIGHT  = 3'd5;
    localparam logic [COLOR_W-1:0] COLOR_MIDDLE = 3'd6;

    // header bits
    localparam int unsigned HDR_LEFT   = 0;
    localparam int unsigned HDR_RIGHT  = 1;
    localparam int unsigned HDR_MIDDLE = 2;
    localparam int unsigned HDR_SYNC   = 3;
    localparam int unsigned HDR_XSIGN  = 4;
    localparam int unsigned HDR_YSIGN  = 5;
    localparam int unsigned HDR_XOVF   = 6;
    localparam int unsigned HDR_YOVF   = 7;

    typedef enum logic [1:0] {
        IDX_HEADER = 2'd0,
        IDX_X      = 2'd1,
        IDX_Y      = 2'd2
    } byte_idx_t;

    typedef enum logic {
        CMD_COLOR = 1'b0,
        CMD_MOVE  = 1'b1
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t                  kind;
        logic [COLOR_W-1:0]         color;
        logic signed [DELTA_W-1:0]  dx;
        logic signed [DELTA_W-1:0]  dy;
    } cmd_t;

    typedef struct packed {
        logic [CFG_W-1:0] screen_w;
        logic [CFG_W-1:0] screen_h;
        logic [CFG_W-1:0] window_w;
        logic [CFG_W-1:0] window_h;
    } cfg_t;

endpackage

FILE: rtl/ps2mt_front.sv
`timescale 1ns / 1ps

module ps2mt_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_valid,
    input  logic              from_aux,
    input  logic [7:0]        data_byte,
    output logic              cmd_push,
    output ps2mt_pkg::cmd_t   cmd
);

    ps2mt_pkg::byte_idx_t idx_reg, idx_next;
    logic [7:0] header_reg, header_next;
    logic [7:0] x_reg, x_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= ps2mt_pkg::IDX_HEADER;
            header_reg <= '0;
            x_reg      <= '0;
        end
        else
        begin
            idx_reg    <= idx_next;
            header_reg <= header_next;
            x_reg      <= x_next;
        end
    end

    always_comb
    begin
        idx_next    = idx_reg;
        header_next = header_reg;
        x_next      = x_reg;
        cmd_push    = 1'b0;
        cmd.kind    = ps2mt_pkg::CMD_MOVE;
        cmd.color   = ps2mt_pkg::COLOR_LEFT;
        cmd.dx      = $signed({header_reg[ps2mt_pkg::HDR_XSIGN], x_reg});
        cmd.dy      = $signed({header_reg[ps2mt_pkg::HDR_YSIGN], data_byte});
        if (byte_valid && from_aux)
        begin
            case (idx_reg)
                ps2mt_pkg::IDX_X:
                begin
                    x_next   = data_byte;
                    idx_next = ps2mt_pkg::IDX_Y;
                end
                ps2mt_pkg::IDX_Y:
                begin
                    idx_next = ps2mt_pkg::IDX_HEADER;
                    // overflow packets are dropped, buttons only recolour
                    if (!(header_reg[ps2mt_pkg::HDR_XOVF] || header_reg[ps2mt_pkg::HDR_YOVF]))
                    begin
                        cmd_push = 1'b1;
                        if (header_reg[ps2mt_pkg::HDR_LEFT])
                        begin
                            cmd.kind  = ps2mt_pkg::CMD_COLOR;
                            cmd.color = ps2mt_pkg::COLOR_LEFT;
                        end
                        else if (header_reg[ps2mt_pkg::HDR_RIGHT])
                        begin
                            cmd.kind  = ps2mt_pkg::CMD_COLOR;
                            cmd.color = ps2mt_pkg::COLOR_RIGHT;
                        end
                        else if (header_reg[ps2mt_pkg::HDR_MIDDLE])
                        begin
                            cmd.kind  = ps2mt_pkg::CMD_COLOR;
                            cmd.color = ps2mt_pkg::COLOR_MIDDLE;
                        end
                    end
                end
                default:
                begin
                    // resync: only a byte with the sync bit starts a packet
                    header_next = data_byte;
                    idx_next    = data_byte[ps2mt_pkg::HDR_SYNC] ? ps2mt_pkg::IDX_X
                                                                 : ps2mt_pkg::IDX_HEADER;
                end
            endcase
        end
    end

endmodule

FILE: rtl/ps2mt_queue.sv
`timescale 1ns / 1ps

module ps2mt_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ps2mt_pkg::cmd_t   push_cmd,
    output logic              full,
    input  logic              pop,
    output logic              not_empty,
    output ps2mt_pkg::cmd_t   head
);

    ps2mt_pkg::cmd_t slot_reg [ps2mt_pkg::QUEUE_DEPTH];
    logic [ps2mt_pkg::QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [ps2mt_pkg::QCNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == ps2mt_pkg::QCNT_W'(ps2mt_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= ps2mt_pkg::QCNT_W'(ps2mt_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push || pop)
        else $error("request pushed into a full queue");
`endif

endmodule

FILE: rtl/ps2mt_back.sv
`timescale 1ns / 1ps

module ps2mt_back
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  ps2mt_pkg::cfg_t                  cfg,
    input  logic                             cmd_valid,
    input  ps2mt_pkg::cmd_t                  cmd,
    output logic                             cmd_pop,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [ps2mt_pkg::POS_W-1:0]      out_x,
    output logic [ps2mt_pkg::POS_W-1:0]      out_y,
    output logic [ps2mt_pkg::COLOR_W-1:0]    out_color,
    output logic [ps2mt_pkg::WIN_W-1:0]      out_win_x,
    output logic [ps2mt_pkg::WIN_W-1:0]      out_win_y
);

    logic [ps2mt_pkg::POS_W-1:0]   pos_x_reg, pos_x_next;
    logic [ps2mt_pkg::POS_W-1:0]   pos_y_reg, pos_y_next;
    logic [ps2mt_pkg::COLOR_W-1:0] color_reg, color_next;
    logic [ps2mt_pkg::WIN_W-1:0]   win_l_reg, win_l_next;
    logic [ps2mt_pkg::WIN_W-1:0]   win_t_reg, win_t_next;
    logic                          valid_reg, valid_next;

    logic signed [ps2mt_pkg::MOVE_W-1:0] nx, ny;
    logic signed [ps2mt_pkg::CMP_W-1:0]  nx_w, ny_w, wl, wt, wr, wb;
    logic signed [ps2mt_pkg::CMP_W-1:0]  sw, sh;
    logic                                drag, pop_move;

    assign cmd_pop  = cmd_valid && (!valid_reg || out_ready);
    assign pop_move = cmd_pop && (cmd.kind == ps2mt_pkg::CMD_MOVE);

    always_comb
    begin
        nx   = $signed({2'b00, pos_x_reg}) + ps2mt_pkg::MOVE_W'(cmd.dx);
        ny   = $signed({2'b00, pos_y_reg}) - ps2mt_pkg::MOVE_W'(cmd.dy);
        nx_w = ps2mt_pkg::CMP_W'(nx);
        ny_w = ps2mt_pkg::CMP_W'(ny);
        wl   = ps2mt_pkg::CMP_W'($signed(win_l_reg));
        wt   = ps2mt_pkg::CMP_W'($signed(win_t_reg));
        wr   = wl + $signed({8'd0, cfg.window_w});
        wb   = wt + $signed({8'd0, cfg.window_h});
        sw   = $signed({8'd0, cfg.screen_w});
        sh   = $signed({8'd0, cfg.screen_h});
        // drag only while left-coloured and strictly inside window and screen
        drag = (color_reg == ps2mt_pkg::COLOR_LEFT)
            && (nx_w > wl) && (nx_w < wr) && (ny_w > wt) && (ny_w < wb)
            && (nx_w > 0) && (nx_w < sw) && (ny_w > 0) && (ny_w < sh);

        pos_x_next = pos_x_reg;
        pos_y_next = pos_y_reg;
        color_next = color_reg;
        win_l_next = win_l_reg;
        win_t_next = win_t_reg;
        valid_next = out_ready ? 1'b0 : valid_reg;

        if (cmd_pop)
        begin
            case (cmd.kind)
                ps2mt_pkg::CMD_COLOR:
                    color_next = cmd.color;
                ps2mt_pkg::CMD_MOVE:
                begin
                    valid_next = 1'b1;
                    if (drag)
                    begin
                        win_l_next = win_l_reg + ps2mt_pkg::WIN_W'(cmd.dx);
                        win_t_next = win_t_reg - ps2mt_pkg::WIN_W'(cmd.dy);
                    end
                    if (nx_w < 0)
                        pos_x_next = '0;
                    else if (nx_w > sw)
                        pos_x_next = cfg.screen_w;
                    else
                        pos_x_next = nx[ps2mt_pkg::POS_W-1:0];
                    if (ny_w < 0)
                        pos_y_next = '0;
                    else if (ny_w > sh)
                        pos_y_next = cfg.screen_h;
                    else
                        pos_y_next = ny[ps2mt_pkg::POS_W-1:0];
                end
                default:
                    color_next = color_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg <= ps2mt_pkg::POS_X_RST;
            pos_y_reg <= ps2mt_pkg::POS_Y_RST;
            color_reg <= ps2mt_pkg::COLOR_INIT;
            win_l_reg <= ps2mt_pkg::WIN_L_RST;
            win_t_reg <= ps2mt_pkg::WIN_T_RST;
            valid_reg <= 1'b0;
        end
        else
        begin
            pos_x_reg <= pos_x_next;
            pos_y_reg <= pos_y_next;
            color_reg <= color_next;
            win_l_reg <= win_l_next;
            win_t_reg <= win_t_next;
            valid_reg <= valid_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = pos_x_reg;
    assign out_y     = pos_y_reg;
    assign out_color = color_reg;
    assign out_win_x = win_l_reg;
    assign out_win_y = win_t_reg;

`ifndef SYNTHESIS
    a_move_reports: assert property (@(posedge clk) disable iff (!rst_n)
        pop_move |=> out_valid)
        else $error("move request gave no result");
    a_colour_taken: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop && cmd.kind == ps2mt_pkg::CMD_COLOR |=> color_reg == $past(cmd.color))
        else $error("colour request not applied");
`endif

endmodule

FILE: rtl/ps2_mouse_packet_cursor_tracker.sv
`timescale 1ns / 1ps

// ps/2 mouse packet decoder and cursor tracker
// input stream: one controller byte per request, s_tuser marks a mouse-port
// byte; other bytes are taken and ignored. s_tready is low only while the
// two-entry command queue between decoder and cursor unit is full.
// the decoder resyncs on headers with bit 3 set and turns each complete
// packet into a colour request (button pressed) or a move request; packets
// with overflow are dropped.
// output stream: one result per move packet, with cursor, colour and window
// state after the move. the third byte of a packet puts its request into the
// queue at acceptance; its result then goes to m_tdata through the output register.
// throughput: one byte per cycle, sustained; a stalled m_tready holds the
// result and fills the queue, after which s_tready drops.
// reset: cursor 160,100, colour 1, window 50,50, screen 320x200, window
// area 100x50, decoder waiting for a header. the user must write registers through
// cfg_we/cfg_index/cfg_data only while the block is idle; the block does not enforce it.
module ps2_mouse_packet_cursor_tracker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tuser,   // from_aux
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // cursor_x, cursor_y, cursor_color, window_x, window_y, pad
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [9:0]  cfg_data
);

    ps2mt_pkg::cfg_t cfg_reg;
    ps2mt_pkg::cmd_t front_cmd, head_cmd;
    logic            front_push, q_full, q_not_empty, q_pop;

    logic [ps2mt_pkg::POS_W-1:0]   out_x, out_y;
    logic [ps2mt_pkg::COLOR_W-1:0] out_color;
    logic [ps2mt_pkg::WIN_W-1:0]   out_win_x, out_win_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.screen_w <= ps2mt_pkg::SCREEN_W_RST;
            cfg_reg.screen_h <= ps2mt_pkg::SCREEN_H_RST;
            cfg_reg.window_w <= ps2mt_pkg::WINDOW_W_RST;
            cfg_reg.window_h <= ps2mt_pkg::WINDOW_H_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ps2mt_pkg::REG_SCREEN_W: cfg_reg.screen_w <= cfg_data;
                ps2mt_pkg::REG_SCREEN_H: cfg_reg.screen_h <= cfg_data;
                ps2mt_pkg::REG_WINDOW_W: cfg_reg.window_w <= cfg_data;
                ps2mt_pkg::REG_WINDOW_H: cfg_reg.window_h <= cfg_data;
                default:                 cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign s_tready = !q_full;

    ps2mt_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (s_tvalid && s_tready),
        .from_aux   (s_tuser),
        .data_byte  (s_tdata),
        .cmd_push   (front_push),
        .cmd        (front_cmd)
    );

    ps2mt_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_push),
        .push_cmd  (front_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (head_cmd)
    );

    ps2mt_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_valid (q_not_empty),
        .cmd       (head_cmd),
        .cmd_pop   (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_x     (out_x),
        .out_y     (out_y),
        .out_color (out_color),
        .out_win_x (out_win_x),
        .out_win_y (out_win_y)
    );

    assign m_tdata = {1'b0, out_win_y, out_win_x, out_color, out_y, out_x};

endmodule
